@@ hw/rtl/key_debounce_long_press_repeat_defines.svh @@
// ----------------------------------------------------------------------------
// key_debounce_long_press_repeat_defines
// assertion macros for the key debounce block, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

// same-cycle implication
`define KDLPR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kdlpr assertion failed");

// next-cycle implication
`define KDLPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kdlpr assertion failed");

`endif

@@ hw/rtl/kdlpr_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlpr_pkg
// shared types, codes and constants of the key debounce block
// ----------------------------------------------------------------------------
`default_nettype none

package kdlpr_pkg;

	localparam int NUM_KEYS = 2;
	localparam int CNT_W    = 16;
	localparam int KEY_W    = 1;
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 2;

	localparam logic [CNT_W-1:0] RESET_DEBOUNCE = CNT_W'(20);
	localparam logic [CNT_W-1:0] RESET_LONG     = CNT_W'(800);
	localparam logic [CNT_W-1:0] RESET_REPEAT   = CNT_W'(200);
	localparam logic [CNT_W-1:0] TIME_MAX       = 16'hFFFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 2'd0,
		KIND_CLICK  = 2'd1,
		KIND_LONG   = 2'd2,
		KIND_REPEAT = 2'd3
	} kind_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_REPEAT     = 2'd2,
		REG_ACTIVE_LOW = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] long_press_ticks;
		logic [CNT_W-1:0] repeat_ticks;
	} timing_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		kind_t            kind;
	} mbox_t;

endpackage

`default_nettype wire

@@ hw/rtl/kdlpr_in_if.sv @@
// ----------------------------------------------------------------------------
// kdlpr_in_if
// command channel: tick samples or mailbox reads
// ----------------------------------------------------------------------------
`default_nettype none

interface kdlpr_in_if #(
	parameter int NUM_KEYS = kdlpr_pkg::NUM_KEYS
);
	logic                valid;
	logic                ready;
	logic                op;
	logic [NUM_KEYS-1:0] raw_levels;

	modport source (output valid, output op, output raw_levels, input ready);
	modport sink   (input valid, input op, input raw_levels, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kdlpr_out_if.sv @@
// ----------------------------------------------------------------------------
// kdlpr_out_if
// event channel: one beat per mailbox read
// ----------------------------------------------------------------------------
`default_nettype none

interface kdlpr_out_if;
	logic                            valid;
	logic                            ready;
	logic [kdlpr_pkg::KEY_W-1:0]     event_key;
	logic [kdlpr_pkg::KIND_W-1:0]    event_kind;

	modport source (output valid, output event_key, output event_kind, input ready);
	modport sink   (input valid, input event_key, input event_kind, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/key_debounce_long_press_repeat.sv @@
// ----------------------------------------------------------------------------
// key_debounce_long_press_repeat
// debounced keys with click, long-press and auto-repeat events
// ----------------------------------------------------------------------------
// Takes one command beat per cycle. A tick beat samples all keys at once: one
// lane per key debounces and times its key in that same cycle, and the merge
// stage posts the lowest-index event into a one-entry mailbox if it is empty.
// A read beat returns the mailbox on the event channel in the next cycle and
// clears it; the event register frees itself in the cycle its beat is taken,
// so commands keep flowing at one per cycle as long as the event sink keeps
// up. Configuration writes take effect on the next tick.
`default_nettype none

`include "key_debounce_long_press_repeat_defines.svh"

module key_debounce_long_press_repeat #(
	parameter int NUM_KEYS = kdlpr_pkg::NUM_KEYS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [kdlpr_pkg::IDX_W-1:0]   cfg_idx,
	input  wire logic [kdlpr_pkg::CNT_W-1:0]   cfg_data,
	kdlpr_in_if.sink                           cmd,
	kdlpr_out_if.source                        evt
);

	kdlpr_pkg::timing_t timing_q;
	logic               active_low_q;
	logic               cmd_fire;
	logic               tick;
	logic               rd;
	logic               evt_valid_q;
	kdlpr_pkg::mbox_t   evt_q;
	kdlpr_pkg::mbox_t   mbox;
	kdlpr_pkg::kind_t   lane_kind [NUM_KEYS];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.debounce_ticks   <= kdlpr_pkg::RESET_DEBOUNCE;
			timing_q.long_press_ticks <= kdlpr_pkg::RESET_LONG;
			timing_q.repeat_ticks     <= kdlpr_pkg::RESET_REPEAT;
			active_low_q              <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				kdlpr_pkg::REG_DEBOUNCE:   timing_q.debounce_ticks   <= cfg_data;
				kdlpr_pkg::REG_LONG_PRESS: timing_q.long_press_ticks <= cfg_data;
				kdlpr_pkg::REG_REPEAT:     timing_q.repeat_ticks     <= cfg_data;
				kdlpr_pkg::REG_ACTIVE_LOW: active_low_q              <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cmd.ready = !evt_valid_q || evt.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign tick      = cmd_fire && (cmd.op == kdlpr_pkg::OP_TICK);
	assign rd        = cmd_fire && (cmd.op == kdlpr_pkg::OP_READ);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		kdlpr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.tick   (tick),
			.sample (cmd.raw_levels[k] ^ active_low_q),
			.timing (timing_q),
			.kind   (lane_kind[k])
		);
	end

	kdlpr_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.rd        (rd),
		.lane_kind (lane_kind),
		.mbox      (mbox)
	);

	// event output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (rd) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			evt_q <= mbox;
		end
	end

	assign evt.valid      = evt_valid_q;
	assign evt.event_key  = evt_q.key;
	assign evt.event_kind = evt_q.kind;

	`KDLPR_ASSERT_NEXT(a_read_gives_beat, rd, evt_valid_q && evt_q == $past(mbox))
	`KDLPR_ASSERT_NEXT(a_read_clears, rd, mbox.kind == kdlpr_pkg::KIND_NONE)
	`KDLPR_ASSERT_NEXT(a_mbox_holds, !rd && mbox.kind != kdlpr_pkg::KIND_NONE, $stable(mbox))
	`KDLPR_ASSERT_NOW(a_stall_blocks, evt_valid_q && !evt.ready, !cmd.ready)

endmodule

`default_nettype wire

@@ hw/rtl/kdlpr_lane.sv @@
// ----------------------------------------------------------------------------
// kdlpr_lane
// per-key debouncer and press timer, reports one event kind per tick
// ----------------------------------------------------------------------------
`default_nettype none

module kdlpr_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tick,
	input  wire logic              sample,
	input  wire kdlpr_pkg::timing_t timing,
	output kdlpr_pkg::kind_t       kind
);

	logic                          last_q, last_d;
	logic                          stable_q, stable_d;
	logic                          longr_q, longr_d;
	logic [kdlpr_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [kdlpr_pkg::CNT_W-1:0]   press_q, press_d;
	logic [kdlpr_pkg::CNT_W-1:0]   rpt_q, rpt_d;
	logic [kdlpr_pkg::CNT_W-1:0]   cnt_inc;
	logic [kdlpr_pkg::CNT_W-1:0]   press_inc;
	logic [kdlpr_pkg::CNT_W-1:0]   rpt_inc;

	always_comb begin
		last_d    = last_q;
		stable_d  = stable_q;
		longr_d   = longr_q;
		cnt_d     = cnt_q;
		press_d   = press_q;
		rpt_d     = rpt_q;
		kind      = kdlpr_pkg::KIND_NONE;
		cnt_inc   = kdlpr_pkg::CNT_W'(cnt_q + 1'b1);
		press_inc = (press_q != kdlpr_pkg::TIME_MAX) ?
			kdlpr_pkg::CNT_W'(press_q + 1'b1) : press_q;
		rpt_inc   = kdlpr_pkg::CNT_W'(rpt_q + 1'b1);

		// debounce
		if (sample != last_q) begin
			last_d = sample;
			cnt_d  = '0;
		end else if (cnt_q < timing.debounce_ticks) begin
			cnt_d = cnt_inc;
			if (cnt_inc >= timing.debounce_ticks && stable_q != last_q) begin
				stable_d = last_q;
				if (!last_q) begin
					// release
					if (press_q < timing.long_press_ticks && !longr_q) begin
						kind = kdlpr_pkg::KIND_CLICK;
					end
					press_d = '0;
					rpt_d   = '0;
					longr_d = 1'b0;
				end
			end
		end

		// press timing, press/repeat/long state is untouched above while held
		if (stable_d) begin
			press_d = press_inc;
			if (!longr_q) begin
				if (press_inc >= timing.long_press_ticks) begin
					kind    = kdlpr_pkg::KIND_LONG;
					longr_d = 1'b1;
					rpt_d   = '0;
				end
			end else begin
				rpt_d = rpt_inc;
				if (rpt_inc >= timing.repeat_ticks) begin
					kind  = kdlpr_pkg::KIND_REPEAT;
					rpt_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			stable_q <= 1'b0;
			longr_q  <= 1'b0;
			cnt_q    <= '0;
			press_q  <= '0;
			rpt_q    <= '0;
		end else if (tick) begin
			last_q   <= last_d;
			stable_q <= stable_d;
			longr_q  <= longr_d;
			cnt_q    <= cnt_d;
			press_q  <= press_d;
			rpt_q    <= rpt_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/kdlpr_merge.sv @@
// ----------------------------------------------------------------------------
// kdlpr_merge
// single-entry event mailbox, first event wins, lowest key first in a tick
// ----------------------------------------------------------------------------
`default_nettype none

module kdlpr_merge #(
	parameter int NUM_KEYS = kdlpr_pkg::NUM_KEYS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tick,
	input  wire logic          rd,
	input  wire kdlpr_pkg::kind_t lane_kind [NUM_KEYS],
	output kdlpr_pkg::mbox_t   mbox
);

	kdlpr_pkg::mbox_t mbox_q;
	kdlpr_pkg::mbox_t sel;

	always_comb begin
		sel.key  = '0;
		sel.kind = kdlpr_pkg::KIND_NONE;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (lane_kind[k] != kdlpr_pkg::KIND_NONE) begin
				sel.key  = kdlpr_pkg::KEY_W'(k);
				sel.kind = lane_kind[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbox_q.key  <= '0;
			mbox_q.kind <= kdlpr_pkg::KIND_NONE;
		end else if (rd) begin
			mbox_q.key  <= '0;
			mbox_q.kind <= kdlpr_pkg::KIND_NONE;
		end else if (tick && mbox_q.kind == kdlpr_pkg::KIND_NONE) begin
			mbox_q <= sel;
		end
	end

	assign mbox = mbox_q;

endmodule

`default_nettype wire
